/* hdl/b64v_pkg.sv */
// ----------------------------------------------------------------------------
// b64v_pkg
// Shared types, constants and the base64 character map for the varint decoder.
// ----------------------------------------------------------------------------
package b64v_pkg;

    // Accumulator width of one decoded value (valid range 8..64)
    localparam int unsigned VALUE_BITS = 32;

    // Widths of the external fields
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned SEXT_W  = 6;
    localparam int unsigned PEND_W  = 7;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned GRP_W   = 3;
    localparam int unsigned PAY_W   = 7;

    // Saturation point of the byte index within one value
    localparam logic [GRP_W-1:0] GROUP_MAX = 3'd7;

    // Base64 alphabet offsets
    localparam logic [SEXT_W-1:0] LOWER_BASE = 6'd26;
    localparam logic [SEXT_W-1:0] DIGIT_BASE = 6'd52;
    localparam logic [SEXT_W-1:0] PLUS_CODE  = 6'd62;
    localparam logic [SEXT_W-1:0] SLASH_CODE = 6'd63;

    // Input beat payload
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              frame_end;
    } in_t;

    // Result beat payload
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overflow;
    } out_t;

    // One completed stream byte handed to the varint accumulator
    typedef struct packed {
        logic       byte_vld;
        logic [7:0] data;
        logic       clear;
    } byte_beat_t;

    // Map one ASCII character to its six-bit code; unknown characters give zero
    function automatic logic [SEXT_W-1:0] sextet_of(input logic [CHAR_W-1:0] ch);
        logic [SEXT_W-1:0] code;
        code = '0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            code = SEXT_W'(ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            code = SEXT_W'(ch - 8'h61) + LOWER_BASE;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            code = SEXT_W'(ch - 8'h30) + DIGIT_BASE;
        end else if (ch == 8'h2B) begin
            code = PLUS_CODE;
        end else if (ch == 8'h2F) begin
            code = SLASH_CODE;
        end
        return code;
    endfunction

endpackage

/* hdl/b64v_varint_acc.sv */
// ----------------------------------------------------------------------------
// b64v_varint_acc
// Little-endian base-128 accumulator: folds completed bytes into a value.
// ----------------------------------------------------------------------------
module b64v_varint_acc (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  b64v_pkg::byte_beat_t  beat,
    output logic                  done,
    output b64v_pkg::out_t        result
);

    localparam int unsigned VB   = b64v_pkg::VALUE_BITS;
    localparam int unsigned SH_W = VB + 49;

    logic [VB-1:0]                 acc_reg, acc_next, acc_new, add_bits;
    logic [b64v_pkg::GRP_W-1:0]    grp_reg, grp_next, grp_new;
    logic                          ovf_reg, ovf_next, ovf_new, spill;
    logic [b64v_pkg::PAY_W-1:0]    payload;
    logic [5:0]                    shamt;
    logic [SH_W-1:0]               wide;
    logic [VB+b64v_pkg::VALUE_W-1:0] val_ext;

    // Place the payload at bit 7*index and split off what falls above the top
    always_comb begin
        payload = beat.data[b64v_pkg::PAY_W-1:0];
        shamt   = 6'({3'b000, grp_reg}) * 6'd7;
        wide    = SH_W'(payload) << shamt;
        if (grp_reg == b64v_pkg::GROUP_MAX) begin
            spill    = |payload;
            add_bits = '0;
            grp_new  = grp_reg;
        end else begin
            spill    = |wide[SH_W-1:VB];
            add_bits = wide[VB-1:0];
            grp_new  = grp_reg + 3'd1;
        end
        acc_new = acc_reg | add_bits;
        ovf_new = ovf_reg | spill;
    end

    // Emit on a byte with a clear continuation bit
    assign done            = beat.byte_vld & ~beat.data[7];
    assign val_ext         = {{b64v_pkg::VALUE_W{1'b0}}, acc_new};
    assign result.value    = val_ext[b64v_pkg::VALUE_W-1:0];
    assign result.overflow = ovf_new;

    // Advance state; drop the value after emission or at frame end
    always_comb begin
        acc_next = acc_reg;
        grp_next = grp_reg;
        ovf_next = ovf_reg;
        if (advance) begin
            if (done || beat.clear) begin
                acc_next = '0;
                grp_next = '0;
                ovf_next = 1'b0;
            end else if (beat.byte_vld) begin
                acc_next = acc_new;
                grp_next = grp_new;
                ovf_next = ovf_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            grp_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            grp_reg <= grp_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

/* hdl/base64_varint_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_varint_stream_decoder
// Decodes base64 text into a stream of unsigned LEB128 varint values.
// ----------------------------------------------------------------------------
// One base64 character is taken per beat, one beat every clock cycle while
// s_ready is high; a finished value is registered on the result channel, or in
// the second result register while the first still waits. Each character adds
// six bits to the stream, most significant bit first; characters outside the
// alphabet, padding included, count as six zero bits. Every stream byte
// contributes its low seven bits to the value; a byte with a clear top bit ends
// the value. The value is kept to 32 bits and overflow flags lost payload bits.
// A beat with frame_end set is decoded normally, then leftover bits and any
// unfinished value are dropped. A second result register lets a new character
// in while a finished value still waits for m_ready; the input stalls only
// while two finished values wait.
module base64_varint_stream_decoder (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  b64v_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output b64v_pkg::out_t  m_data
);

    logic [b64v_pkg::PEND_W-1:0]  pend_reg, pend_next;
    logic [b64v_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         m_valid_reg, m_valid_next;
    b64v_pkg::out_t               m_data_reg, m_data_next;
    logic                         sk_valid_reg, sk_valid_next;
    b64v_pkg::out_t               sk_data_reg, sk_data_next;

    logic                         accept;
    logic [b64v_pkg::SEXT_W-1:0]  sextet;
    logic [12:0]                  joined;
    logic [3:0]                   total;
    logic [2:0]                   extra;
    logic [12:0]                  shifted;
    logic [b64v_pkg::PEND_W-1:0]  keep_mask;
    b64v_pkg::byte_beat_t         beat;
    logic                         done;
    b64v_pkg::out_t               result;

    assign s_ready = ~sk_valid_reg;
    assign accept  = s_valid & s_ready;

    // Append the sextet and cut a byte once eight bits are pending
    always_comb begin
        sextet    = b64v_pkg::sextet_of(s_data.char_code);
        joined    = {pend_reg, sextet};
        total     = {1'b0, cnt_reg} + 4'd6;
        extra     = 3'(total - 4'd8);
        shifted   = joined >> extra;
        keep_mask = (7'd1 << extra) - 7'd1;

        beat.clear = s_data.frame_end;
        if (total >= 4'd8) begin
            beat.byte_vld = 1'b1;
            beat.data     = shifted[7:0];
            pend_next     = joined[6:0] & keep_mask;
            cnt_next      = extra;
        end else begin
            beat.byte_vld = 1'b0;
            beat.data     = shifted[7:0];
            pend_next     = joined[6:0];
            cnt_next      = total[2:0];
        end

        // drop leftover bits at frame end; hold when no beat
        if (!accept) begin
            pend_next = pend_reg;
            cnt_next  = cnt_reg;
        end else if (s_data.frame_end) begin
            pend_next = '0;
            cnt_next  = '0;
        end
    end

    b64v_varint_acc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (accept),
        .beat    (beat),
        .done    (done),
        .result  (result)
    );

    // Load a finished value into the head or the skid register, advance on take
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        sk_valid_next = sk_valid_reg;
        sk_data_next  = sk_data_reg;
        if (m_valid_reg && m_ready) begin
            if (sk_valid_reg) begin
                m_data_next   = sk_data_reg;
                sk_valid_next = 1'b0;
            end else if (accept && done) begin
                m_data_next = result;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (accept && done) begin
            if (!m_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = result;
            end else begin
                sk_valid_next = 1'b1;
                sk_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else begin
            pend_reg     <= pend_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            sk_valid_reg <= sk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        sk_data_reg <= sk_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 to varint stream decoder. Base64 text
// built from random varint byte streams, together with truncated frames and
// raw character noise, is fed through the input channel. The bench tracks the
// bit stream and value accumulator itself, and each result beat is checked
// against the oldest predicted value. Sender gaps and receiver stalls change
// from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned VB         = b64v_pkg::VALUE_BITS;
    localparam int unsigned VALUE_W    = b64v_pkg::VALUE_W;
    localparam int unsigned PEND_W     = b64v_pkg::PEND_W;
    localparam int unsigned CNT_W      = b64v_pkg::CNT_W;
    localparam int unsigned GRP_W      = b64v_pkg::GRP_W;
    localparam logic [63:0] ACC_MASK   = (VB >= 64) ? '1 : ((64'd1 << VB) - 64'd1);
    localparam int          QUIET_MAX  = 4000;
    localparam int          TAIL_WAIT  = 16;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    b64v_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    b64v_pkg::out_t m_data;

    // Stimulus and scoreboard storage
    b64v_pkg::in_t  char_q[$];
    b64v_pkg::out_t decoded_q[$];
    logic [7:0]     frame_bytes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int queued         = 0;
    int beats_in       = 0;
    int values_seen    = 0;
    int ovf_values     = 0;
    int frames_closed  = 0;
    int errors         = 0;
    int quiet          = 0;

    // Decoder state as tracked by the bench
    logic [PEND_W-1:0] pend_bits = '0;
    logic [CNT_W-1:0]  pend_cnt  = '0;
    logic [63:0]       acc       = '0;
    logic [GRP_W-1:0]  grp       = '0;
    logic              ovf       = 1'b0;

    base64_varint_stream_decoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Classify one character: {in alphabet, six-bit code}
    function automatic logic [6:0] lookup(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= "A" && c <= "Z") begin
            r = {1'b1, 6'(c - "A")};
        end else if (c >= "a" && c <= "z") begin
            r = {1'b1, 6'(c - "a") + b64v_pkg::LOWER_BASE};
        end else if (c >= "0" && c <= "9") begin
            r = {1'b1, 6'(c - "0") + b64v_pkg::DIGIT_BASE};
        end else if (c == "+") begin
            r = {1'b1, b64v_pkg::PLUS_CODE};
        end else if (c == "/") begin
            r = {1'b1, b64v_pkg::SLASH_CODE};
        end
        return r;
    endfunction

    // Six-bit code back to its base64 character
    function automatic logic [7:0] char_of(input logic [5:0] sx);
        if (sx < b64v_pkg::LOWER_BASE) return "A" + 8'(sx);
        if (sx < b64v_pkg::DIGIT_BASE) return "a" + 8'(sx - b64v_pkg::LOWER_BASE);
        if (sx < b64v_pkg::PLUS_CODE)  return "0" + 8'(sx - b64v_pkg::DIGIT_BASE);
        if (sx == b64v_pkg::PLUS_CODE) return "+";
        return "/";
    endfunction

    // Any character outside the alphabet; decodes as six zero bits
    function automatic logic [7:0] foreign_char();
        logic [7:0] c;
        logic [6:0] k;
        do begin
            c = 8'($urandom_range(255));
            k = lookup(c);
        end while (k[6]);
        return c;
    endfunction

    function automatic void clear_value();
        acc = '0;
        grp = '0;
        ovf = 1'b0;
    endfunction

    // Advance the tracked decoder by one character; return 1 when a value completes
    function automatic bit decode_char(input b64v_pkg::in_t beat, output b64v_pkg::out_t res);
        logic [6:0]  k;
        logic [12:0] joined;
        logic [7:0]  octet;
        logic [6:0]  pay;
        int unsigned total, extra, shift, room;
        bit          done;
        done   = 1'b0;
        res    = '0;
        k      = lookup(beat.char_code);
        joined = {6'(pend_bits), k[5:0]};
        total  = int'(pend_cnt) + 6;
        if (total >= 8) begin
            extra     = total - 8;
            octet     = 8'(joined >> extra);
            pay       = octet[6:0];
            pend_bits = PEND_W'(joined & ((13'd1 << extra) - 13'd1));
            pend_cnt  = CNT_W'(extra);
            if (grp >= b64v_pkg::GROUP_MAX) begin
                // Saturated index: payload lies beyond the accumulator
                if (pay != 0) ovf = 1'b1;
            end else begin
                shift = 7 * int'(grp);
                if (shift >= VB) begin
                    if (pay != 0) ovf = 1'b1;
                end else begin
                    room = VB - shift;
                    if (room < 7 && (pay >> room) != 0) ovf = 1'b1;
                    acc = (acc | (64'(pay) << shift)) & ACC_MASK;
                end
                grp = grp + 1'b1;
            end
            if (!octet[7]) begin
                res.value    = acc[VALUE_W-1:0];
                res.overflow = ovf;
                done         = 1'b1;
                clear_value();
            end
        end else begin
            pend_bits = joined[6:0];
            pend_cnt  = CNT_W'(total);
        end
        // Frame end drops leftover bits and any unfinished value
        if (beat.frame_end) begin
            pend_bits = '0;
            pend_cnt  = '0;
            clear_value();
        end
        return done;
    endfunction

    task automatic push_char(input logic [7:0] c, input logic fend);
        b64v_pkg::in_t it;
        it.char_code = c;
        it.frame_end = fend;
        char_q.insert(char_q.size(), it);
        queued++;
    endtask

    // Turn frame_bytes into base64 text, optionally padded or cut short, and queue it
    task automatic encode_emit(input bit with_end, input bit broken);
        bit         stream[$];
        logic [7:0] txt[$];
        logic [5:0] sx;
        int         k, cut;
        foreach (frame_bytes[i]) begin
            for (k = 7; k >= 0; k--) stream.insert(stream.size(), frame_bytes[i][k]);
        end
        while (stream.size() > 0) begin
            sx = '0;
            for (k = 0; k < 6; k++) begin
                if (stream.size() > 0) sx = {sx[4:0], stream.pop_front()};
                else sx = {sx[4:0], 1'b0};
            end
            if (sx == 0 && $urandom_range(3) == 0) txt.insert(txt.size(), foreign_char());
            else txt.insert(txt.size(), char_of(sx));
        end
        if (!broken && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) txt.insert(txt.size(), "=");
        end
        if (broken && txt.size() > 1 && $urandom_range(1) == 1) begin
            cut = $urandom_range(1, (txt.size() > 3) ? 3 : txt.size() - 1);
            repeat (cut) void'(txt.pop_back());
        end
        foreach (txt[i]) push_char(txt[i], with_end && (i == txt.size() - 1));
    endtask

    // One frame of varints; a broken frame may leave its last value open or lose its tail
    task automatic add_frame(input bit broken);
        int         nvals, len, r, v, i;
        bit         open_end;
        logic [6:0] pay;
        frame_bytes = {};
        nvals    = $urandom_range(1, 3);
        open_end = broken && ($urandom_range(1) == 1);
        for (v = 0; v < nvals; v++) begin
            r = $urandom_range(9);
            if (r < 6) len = $urandom_range(1, 3);
            else if (r < 9) len = $urandom_range(4, 5);
            else len = $urandom_range(6, 10);
            for (i = 0; i < len; i++) begin
                pay = 7'($urandom_range(127));
                if ($urandom_range(3) == 0) pay = 7'($urandom_range(3));
                frame_bytes.insert(frame_bytes.size(),
                                   {(i != len - 1) || (open_end && v == nvals - 1), pay});
            end
        end
        encode_emit(broken || ($urandom_range(4) != 0), broken);
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 8)) begin
            push_char(8'($urandom_range(255)), $urandom_range(5) == 0);
        end
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int n_items);
        int target, r;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        target         = queued + n_items;
        while (queued < target) begin
            r = $urandom_range(99);
            if (r < 75) add_frame(1'b0);
            else if (r < 90) add_frame(1'b1);
            else add_noise();
        end
        while (beats_in < queued) @(posedge aclk);
    endtask

    // Driver: present the next character, hold it until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_ready) begin
                if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= char_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on each input beat, check each result beat
    always @(posedge aclk) begin : monitor
        b64v_pkg::out_t want, got;
        if (!aresetn) begin
            pend_bits = '0;
            pend_cnt  = '0;
            clear_value();
        end else begin
            if (s_valid && s_ready) begin
                if (decode_char(s_data, want)) decoded_q.insert(decoded_q.size(), want);
                if (s_data.frame_end) frames_closed++;
                beats_in++;
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: value %h overflow %b", got.value, got.overflow);
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got.value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, got.value);
                        errors++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow: expected %b, got %b", want.overflow, got.overflow);
                        errors++;
                    end
                end
                values_seen++;
                if (got.overflow === 1'b1) ovf_values++;
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_MAX) begin
            $display("no handshake for %0d cycles", QUIET_MAX);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: alphabet extremes in one frame
        push_char("A", 1'b0);
        push_char("Z", 1'b0);
        push_char("a", 1'b0);
        push_char("z", 1'b0);
        push_char("0", 1'b0);
        push_char("9", 1'b0);
        push_char("+", 1'b0);
        push_char("/", 1'b1);
        // Directed: nine-byte value, straddles the top and saturates the index
        frame_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        encode_emit(1'b1, 1'b0);
        // Directed: padding and codes outside the alphabet, frame end on a byte boundary
        push_char("=", 1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h80, 1'b1);

        run_phase(0, 0, 226);
        run_phase(62, 0, 230);
        run_phase(0, 62, 230);
        run_phase(30, 30, 230);
        run_phase(0, 0, 230);

        // Drain outstanding results, then let the pipeline settle
        while (decoded_q.size() > 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("summary: %0d characters in %0d closed frames, %0d values checked",
                 beats_in, frames_closed, values_seen);
        $display("summary: %0d values flagged overflow, %0d mismatches", ovf_values, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
